@@ hw/rtl/fqrp_pkg.sv @@
// shared types, codes and constants of the fifo queue with remove and peek
package fqrp_pkg;

  // defaults for the top level parameters
  localparam int DefDepth     = 16;
  localparam int DefDataWidth = 32;

  // fixed field widths of the stream ports
  localparam int IoDataW   = 32;
  localparam int PosW      = 4;
  localparam int OccW      = 5;
  localparam int CmdW      = 2;
  localparam int StatusW   = 2;
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 40;
  localparam int OutTuserW = 3;

  // request commands
  typedef enum logic [CmdW-1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_DONE
  } state_e;

  // read address source for a single read
  typedef enum logic {
    RD_HEAD,
    RD_POS
  } rd_src_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    latch;
    logic    enq_wr;
    logic    rd_issue;
    rd_src_e rd_src;
    logic    pop;
    logic    scan_start;
    logic    scan_step;
    logic    finish;
    logic    fin_data;
    status_e fin_status;
    logic    fin_rem;
    logic    out_load;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic full;
    logic pos_ok;
    logic scan_last;
  } stat_t;

endpackage

@@ hw/rtl/fifo_queue_with_remove_and_peek.sv @@
// top level of the fifo queue with remove and peek
//
// Commands arrive on the s_axis channel: enqueue, dequeue, peek at a
// position counted from the head, or remove the first entry equal to a
// word. Each accepted request yields exactly one result on m_axis with
// the word found, a hit flag, the new occupancy and a status.
// Entries sit in a circular memory with one read and one write port;
// dequeue moves the head pointer, remove closes the gap by moving the
// following entries one place toward the head.
// One request is worked at a time: enqueue and every refused command
// (empty, full or position out of range) need no memory read, dequeue
// and peek need one memory read, and remove streams every held entry
// through the read port for the scan and the compaction. A new request
// is taken only once the last result has moved to the output register.
// Reset empties the queue and clears the output valid; memory contents
// are not cleared and no clearing pass runs.
// A result waits in the output register while the receiver stalls; the
// next request is still taken and worked, and its result waits
// internally until the output register frees.
module fifo_queue_with_remove_and_peek
  import fqrp_pkg::*;
#(
  parameter int DEPTH      = DefDepth,
  parameter int DATA_WIDTH = DefDataWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // value [31:0], position [35:32], zero pad [39:36]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // command [1:0]
  input  logic [CmdW-1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // data_out [31:0], occupancy [36:32], zero pad [39:37]
  output logic [OutTdataW-1:0] m_axis_tdata,
  // hit [0], status [2:1]
  output logic [OutTuserW-1:0] m_axis_tuser
);

  ctrl_t              ctrl;
  stat_t              stat;
  logic [IoDataW-1:0] out_data;
  logic               out_hit;
  logic [OccW-1:0]    out_occ;
  logic [StatusW-1:0] out_status;

  // sequencing
  fqrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // storage and result path
  fqrp_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .cmd_i        (s_axis_tuser),
    .value_i      (s_axis_tdata[IoDataW-1:0]),
    .pos_i        (s_axis_tdata[IoDataW +: PosW]),
    .out_data_o   (out_data),
    .out_hit_o    (out_hit),
    .out_occ_o    (out_occ),
    .out_status_o (out_status)
  );

  // result packing
  assign m_axis_tdata = {{(OutTdataW - IoDataW - OccW){1'b0}}, out_occ, out_data};
  assign m_axis_tuser = {out_status, out_hit};

endmodule

@@ hw/rtl/fqrp_dpath.sv @@
// datapath: circular entry memory, pointers, scan and compaction, result registers
module fqrp_dpath
  import fqrp_pkg::*;
#(
  parameter int DEPTH      = DefDepth,
  parameter int DATA_WIDTH = DefDataWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  input  logic [CmdW-1:0]    cmd_i,
  input  logic [IoDataW-1:0] value_i,
  input  logic [PosW-1:0]    pos_i,
  output logic [IoDataW-1:0] out_data_o,
  output logic               out_hit_o,
  output logic [OccW-1:0]    out_occ_o,
  output logic [StatusW-1:0] out_status_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CmpW = (PosW > CW) ? PosW : CW;
  localparam logic [AW:0]   DepthA = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  // logical index from head to memory address, wrapping at DEPTH
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthA) begin
      sum = sum - DepthA;
    end
    return sum[AW-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  cmd_e                  cmd_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [PosW-1:0]       pos_q;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] cmp_idx_q, cmp_idx_d;
  logic          found_q, found_d;

  logic [IoDataW-1:0] res_data_q;
  logic               res_hit_q;
  status_e            res_status_q;

  logic [IoDataW-1:0] out_data_q;
  logic               out_hit_q;
  logic [OccW-1:0]    out_occ_q;
  logic [StatusW-1:0] out_status_q;

  logic                  match_now;
  logic                  found_any;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  // scan compare on the word that arrived from memory
  assign match_now = !found_q && (rd_data_q == value_q);
  assign found_any = found_q || match_now;

  // status toward the controller
  assign stat_o.cmd       = cmd_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == DepthC);
  assign stat_o.pos_ok    = (CmpW'(pos_q) < CmpW'(count_q));
  assign stat_o.scan_last = (cmp_idx_q == count_q - CW'(1));

  // memory read port: single reads, then the scan stream
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = phys(head_q, rd_idx_q[AW-1:0]);
    if (ctrl_i.rd_issue) begin
      rd_en = 1'b1;
      if (ctrl_i.rd_src == RD_POS) begin
        rd_addr = phys(head_q, AW'(pos_q));
      end else begin
        rd_addr = head_q;
      end
    end else if (ctrl_i.scan_step && (rd_idx_q < count_q)) begin
      rd_en = 1'b1;
    end
  end

  // memory write port: enqueue at the tail or move a word one place toward the head
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys(head_q, count_q[AW-1:0]);
    wr_data = value_q;
    if (ctrl_i.enq_wr) begin
      wr_en = 1'b1;
    end else if (ctrl_i.scan_step && found_q) begin
      wr_en   = 1'b1;
      wr_addr = phys(head_q, cmp_idx_q[AW-1:0] - AW'(1));
      wr_data = rd_data_q;
    end
  end

  // entry memory with registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // pointer, count and scan index updates
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    found_d   = found_q;
    if (ctrl_i.enq_wr) begin
      count_d = count_q + CW'(1);
    end
    if (ctrl_i.pop) begin
      head_d  = phys(head_q, AW'(1));
      count_d = count_q - CW'(1);
    end
    if (ctrl_i.scan_start) begin
      rd_idx_d  = CW'(1);
      cmp_idx_d = '0;
      found_d   = 1'b0;
    end
    if (ctrl_i.scan_step) begin
      rd_idx_d  = rd_idx_q + CW'(1);
      cmp_idx_d = cmp_idx_q + CW'(1);
      found_d   = found_any;
    end
    if (ctrl_i.fin_rem && found_any) begin
      count_d = count_q - CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      found_q   <= 1'b0;
    end else begin
      head_q    <= head_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      cmp_idx_q <= cmp_idx_d;
      found_q   <= found_d;
    end
  end

  // request capture, result and output registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q   <= cmd_e'(cmd_i);
      value_q <= DATA_WIDTH'(value_i);
      pos_q   <= pos_i;
    end
    if (ctrl_i.finish) begin
      res_data_q   <= ctrl_i.fin_data ? IoDataW'(rd_data_q) : '0;
      res_hit_q    <= ctrl_i.fin_data;
      res_status_q <= ctrl_i.fin_status;
    end else if (ctrl_i.fin_rem) begin
      res_data_q   <= '0;
      res_hit_q    <= found_any;
      res_status_q <= found_any ? ST_OK : ST_NOTFOUND;
    end
    if (ctrl_i.out_load) begin
      out_data_q   <= res_data_q;
      out_hit_q    <= res_hit_q;
      out_occ_q    <= OccW'(count_q);
      out_status_q <= res_status_q;
    end
  end

  assign out_data_o   = out_data_q;
  assign out_hit_o    = out_hit_q;
  assign out_occ_o    = out_occ_q;
  assign out_status_o = out_status_q;

  // enqueue never writes into a full queue
  a_enq_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.enq_wr |-> (count_q != DepthC))
    else $error("enqueue write while full");

  // a pop leaves the count one lower
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |=> (count_q == $past(count_q) - CW'(1)))
    else $error("pop did not lower the count");

  // compaction only moves words that follow the removed entry
  a_shift_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.scan_step && found_q) |-> (cmp_idx_q != '0))
    else $error("compaction write at the head");

endmodule

@@ hw/rtl/fqrp_ctrl.sv @@
// controller: command sequencing state machine and output valid
module fqrp_ctrl
  import fqrp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    ctrl_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (stat_i.cmd)
          CMD_ENQ: begin
            ctrl_o.finish = 1'b1;
            if (stat_i.full) begin
              ctrl_o.fin_status = ST_FULL;
            end else begin
              ctrl_o.enq_wr     = 1'b1;
              ctrl_o.fin_status = ST_OK;
            end
          end
          CMD_DEQ: begin
            if (stat_i.empty) begin
              ctrl_o.finish     = 1'b1;
              ctrl_o.fin_status = ST_EMPTY;
            end else begin
              ctrl_o.rd_issue = 1'b1;
              ctrl_o.rd_src   = RD_HEAD;
              state_d         = S_RDWAIT;
            end
          end
          CMD_PEEK: begin
            if (!stat_i.pos_ok) begin
              ctrl_o.finish     = 1'b1;
              ctrl_o.fin_status = ST_NOTFOUND;
            end else begin
              ctrl_o.rd_issue = 1'b1;
              ctrl_o.rd_src   = RD_POS;
              state_d         = S_RDWAIT;
            end
          end
          CMD_REMOVE: begin
            if (stat_i.empty) begin
              ctrl_o.finish     = 1'b1;
              ctrl_o.fin_status = ST_NOTFOUND;
            end else begin
              ctrl_o.rd_issue   = 1'b1;
              ctrl_o.rd_src     = RD_HEAD;
              ctrl_o.scan_start = 1'b1;
              state_d           = S_SCAN;
            end
          end
          default: begin
            ctrl_o.finish     = 1'b1;
            ctrl_o.fin_status = ST_NOTFOUND;
          end
        endcase
      end
      S_RDWAIT: begin
        ctrl_o.finish     = 1'b1;
        ctrl_o.fin_data   = 1'b1;
        ctrl_o.fin_status = ST_OK;
        ctrl_o.pop        = (stat_i.cmd == CMD_DEQ);
        state_d           = S_DONE;
      end
      S_SCAN: begin
        ctrl_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          ctrl_o.fin_rem = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // a result is loaded only into a free or draining output slot
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote an unread result");

  // a new result appears only from the done state
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("output valid raised outside done state");

endmodule
